@@ src/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int STATUS_WIDTH     = 2;
   localparam int COUNT_PORT_WIDTH = 8;
   localparam int DEFAULT_DEPTH    = 128;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                          enq;
      logic                          deq;
      logic signed [VALUE_WIDTH-1:0] value;
   } cmd_type;

endpackage
`default_nettype wire

@@ src/spq_cell.sv @@
`default_nettype none
module spq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 8
) (
   input  wire logic                                  clock,
   input  wire spq_pkg::cmd_type                      cmd,
   input  wire logic [CNT_W-1:0]                      count,
   input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] upper_value,
   input  wire logic                                  upper_gt,
   input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0] lower_value,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0]      value,
   output logic                                       gt
);
   import spq_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic                          occupied;

   assign occupied = count > CNT_W'(INDEX);
   assign gt       = occupied && (value_ff > cmd.value);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.enq) begin
         if (gt) begin
            value_in = value_ff;
         end else if (upper_gt) begin
            value_in = cmd.value;
         end else begin
            value_in = upper_value;
         end
      end else if (cmd.deq) begin
         value_in = lower_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

@@ src/sorted_priority_queue.sv @@
`default_nettype none
// Max-priority queue of signed 32-bit values built as a chain of DEPTH cells,
// largest at the head. Each request (enqueue or dequeue) gives one response
// carrying status, the removed value and the entry count after the request.
// One request is accepted every clock cycle while req_stall is low: all
// cells compare the new value against their own in parallel and shift toward
// or away from the head together, and the response is registered. Equal
// values leave newest first. A full queue refuses an enqueue (overflow), an
// empty one refuses a dequeue (underflow); state is unchanged in both cases.
// A two-deep response buffer lets requests keep flowing while one response is
// stalled; req_stall rises only when both entries are held.
module sorted_priority_queue #(
   parameter int DEPTH = spq_pkg::DEFAULT_DEPTH
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire logic                                       req_type,
   input  wire logic signed [spq_pkg::VALUE_WIDTH-1:0]     req_item_value,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic [spq_pkg::STATUS_WIDTH-1:0]                rsp_status,
   output logic signed [spq_pkg::VALUE_WIDTH-1:0]          rsp_removed_value,
   output logic [spq_pkg::COUNT_PORT_WIDTH-1:0]            rsp_entry_count
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]       status;
      logic signed [VALUE_WIDTH-1:0] removed;
      logic [COUNT_PORT_WIDTH-1:0]   count;
   } rsp_type;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             accept;
   logic             full;
   logic             empty;
   cmd_type          cmd;
   rsp_type          result;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          skid_valid_ff, skid_valid_in;
   rsp_type                       rsp_ff, rsp_in;
   rsp_type                       skid_ff, skid_in;
   logic                          rsp_take;

   logic signed [VALUE_WIDTH-1:0] value_w     [DEPTH];
   logic                          gt_w        [DEPTH];
   logic signed [VALUE_WIDTH-1:0] up_value_w  [DEPTH];
   logic                          up_gt_w     [DEPTH];
   logic signed [VALUE_WIDTH-1:0] low_value_w [DEPTH];

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;

   assign cmd.enq   = accept && (req_type == REQ_ENQUEUE) && !full;
   assign cmd.deq   = accept && (req_type == REQ_DEQUEUE) && !empty;
   assign cmd.value = req_item_value;

   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      result.status  = STATUS_OK;
      result.removed = '0;
      result.count   = COUNT_PORT_WIDTH'(count_in);
      if (req_type == REQ_ENQUEUE) begin
         if (full) begin
            result.status = STATUS_OVERFLOW;
         end
      end else begin
         if (empty) begin
            result.status = STATUS_UNDERFLOW;
         end else begin
            result.removed = value_w[0];
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign up_value_w[i] = cmd.value;
         assign up_gt_w[i]    = 1'b1;
      end else begin : g_body
         assign up_value_w[i] = value_w[i-1];
         assign up_gt_w[i]    = gt_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign low_value_w[i] = value_w[i];
      end else begin : g_link
         assign low_value_w[i] = value_w[i+1];
      end

      spq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .upper_value (up_value_w[i]),
         .upper_gt    (up_gt_w[i]),
         .lower_value (low_value_w[i]),
         .value       (value_w[i]),
         .gt          (gt_w[i])
      );
   end

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_removed_value = rsp_ff.removed;
   assign rsp_entry_count   = rsp_ff.count;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("buffered response without head response");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_OVERFLOW)
         |-> rsp_ff.count == COUNT_PORT_WIDTH'(DEPTH))
      else $error("overflow reported while not full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_UNDERFLOW)
         |-> (rsp_ff.count == '0 && rsp_ff.removed == '0))
      else $error("underflow reported while not empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.enq || cmd.deq) |=> count_ff != $past(count_ff))
      else $error("entry count did not move on a granted request");
`endif

endmodule
`default_nettype wire
